FILE: hw/rtl/mscg_pkg.sv
// Shared types and constants of the multi-stop colour gradient.
`timescale 1ns / 1ps

package mscg_pkg;

  localparam int unsigned POS_W         = 10;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned COLOR_W       = 3 * CHAN_W;
  localparam int unsigned LANES         = 3;
  localparam int unsigned CNT_W         = 3;
  localparam int unsigned IDX_W         = 3;
  localparam int unsigned NUM_STOP_REGS = 7;
  localparam int unsigned STOP_W        = POS_W + COLOR_W;
  // Blend numerator: at most 255 * 1023, which fits 18 bits.
  localparam int unsigned NUM_W         = POS_W + CHAN_W;
  localparam int unsigned QUO_W         = CHAN_W;
  localparam int unsigned FIFO_DEPTH    = 4;

  localparam int unsigned MAX_STOPS_DEF     = 7;
  localparam int unsigned POSITION_SPAN_DEF = 1024;

  localparam int unsigned APB_DW = 64;
  localparam int unsigned APB_AW = 6;

  typedef enum logic [IDX_W-1:0] {
    REG_STOP_COUNT = 3'd0,
    REG_STOP_0     = 3'd1,
    REG_STOP_1     = 3'd2,
    REG_STOP_2     = 3'd3,
    REG_STOP_3     = 3'd4,
    REG_STOP_4     = 3'd5,
    REG_STOP_5     = 3'd6,
    REG_STOP_6     = 3'd7
  } mscg_reg_e;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } mscg_stop_t;

  // One queued job: colour = (lo * (span - offset) + hi * offset) / span.
  typedef struct packed {
    logic [POS_W-1:0]   span;
    logic [POS_W-1:0]   offset;
    logic [COLOR_W-1:0] lo_color;
    logic [COLOR_W-1:0] hi_color;
  } mscg_entry_t;

endpackage

FILE: hw/rtl/mscg_cfg.sv
// Register file of the gradient: stop count and colour stops behind an APB-style port.
`timescale 1ns / 1ps

module mscg_cfg (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [mscg_pkg::APB_AW-1:0]               paddr,
  input  logic [mscg_pkg::APB_DW-1:0]               pwdata,
  output logic [mscg_pkg::APB_DW-1:0]               prdata,
  output logic                                      pready,
  output logic [mscg_pkg::CNT_W-1:0]                stop_count_o,
  output mscg_pkg::mscg_stop_t                      stops_o [mscg_pkg::NUM_STOP_REGS]
);
  import mscg_pkg::*;

  logic [CNT_W-1:0]  count_q;
  mscg_stop_t        stop_q [NUM_STOP_REGS];
  logic [IDX_W-1:0]  reg_idx;
  logic [IDX_W-1:0]  stop_idx;
  logic              wr_en;

  assign reg_idx  = paddr[APB_AW-1:APB_AW-IDX_W];
  assign stop_idx = reg_idx - IDX_W'(1);
  assign wr_en    = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < NUM_STOP_REGS; i++) begin
        stop_q[i] <= '0;
      end
    end else if (wr_en) begin
      if (reg_idx == REG_STOP_COUNT) begin
        count_q <= pwdata[CNT_W-1:0];
      end else begin
        stop_q[stop_idx] <= pwdata[STOP_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == REG_STOP_COUNT) begin
      prdata = APB_DW'(count_q);
    end else begin
      prdata = APB_DW'(stop_q[stop_idx]);
    end
  end

  assign stop_count_o = count_q;
  assign stops_o      = stop_q;

endmodule

FILE: hw/rtl/mscg_front.sv
// Front end: accepts positions, finds the bracketing stops and forms the blend job.
`timescale 1ns / 1ps

module mscg_front #(
  parameter int unsigned MAX_STOPS     = mscg_pkg::MAX_STOPS_DEF,
  parameter int unsigned POSITION_SPAN = mscg_pkg::POSITION_SPAN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mscg_pkg::POS_W-1:0]     position_i,
  input  logic [mscg_pkg::CNT_W-1:0]     stop_count_i,
  input  mscg_pkg::mscg_stop_t           stops_i [mscg_pkg::NUM_STOP_REGS],
  output logic                           ent_valid_o,
  input  logic                           ent_ready_i,
  output mscg_pkg::mscg_entry_t          ent_o
);
  import mscg_pkg::*;

  localparam int unsigned PosTopInt =
      (POSITION_SPAN - 1 > (1 << POS_W) - 1) ? (1 << POS_W) - 1 : POSITION_SPAN - 1;
  localparam logic [POS_W-1:0] PosTop = POS_W'(PosTopInt);

  typedef enum logic [1:0] {
    KIND_BLACK,
    KIND_FIRST,
    KIND_LAST,
    KIND_BLEND
  } kind_e;

  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
    return (p > PosTop) ? PosTop : p;
  endfunction

  function automatic logic [COLOR_W-1:0] color_of(input mscg_stop_t s);
    return {s.red, s.green, s.blue};
  endfunction

  logic             ent_valid_q;
  mscg_entry_t      ent_q;
  mscg_entry_t      ent_d;
  logic [POS_W-1:0] pos_c;
  logic [CNT_W-1:0] n_c;
  logic [IDX_W-1:0] k_c;
  logic [IDX_W-1:0] last_c;
  logic [IDX_W-1:0] prev_c;
  logic             found_c;
  logic [POS_W-1:0] lo_pos;
  kind_e            kind;

  assign pos_c  = clamp_pos(position_i);
  assign n_c    = (stop_count_i > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : stop_count_i;
  assign last_c = n_c - CNT_W'(1);
  assign prev_c = k_c - IDX_W'(1);
  assign lo_pos = clamp_pos(stops_i[prev_c].pos);

  // First valid stop whose position is not below the input.
  always_comb begin
    found_c = 1'b0;
    k_c     = '0;
    for (int j = 0; j < MAX_STOPS; j++) begin
      if (!found_c && (CNT_W'(j) < n_c) && (pos_c <= clamp_pos(stops_i[j].pos))) begin
        found_c = 1'b1;
        k_c     = IDX_W'(j);
      end
    end
  end

  always_comb begin
    priority if (n_c == '0) begin
      kind = KIND_BLACK;
    end else if (!found_c) begin
      kind = KIND_LAST;
    end else if (k_c == '0) begin
      kind = KIND_FIRST;
    end else begin
      kind = KIND_BLEND;
    end
  end

  // Flat colours travel as a blend over a span of one with no offset.
  always_comb begin
    ent_d.span     = POS_W'(1);
    ent_d.offset   = '0;
    ent_d.lo_color = '0;
    ent_d.hi_color = '0;
    unique case (kind)
      KIND_BLACK: begin
        ent_d.lo_color = '0;
      end
      KIND_FIRST: begin
        ent_d.lo_color = color_of(stops_i[0]);
      end
      KIND_LAST: begin
        ent_d.lo_color = color_of(stops_i[last_c]);
      end
      KIND_BLEND: begin
        ent_d.span     = clamp_pos(stops_i[k_c].pos) - lo_pos;
        ent_d.offset   = pos_c - lo_pos;
        ent_d.lo_color = color_of(stops_i[prev_c]);
        ent_d.hi_color = color_of(stops_i[k_c]);
      end
      default: begin
        ent_d.lo_color = '0;
      end
    endcase
  end

  assign in_ready_o = !ent_valid_q || ent_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      ent_valid_q <= 1'b1;
    end else if (ent_ready_i) begin
      ent_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ent_q <= ent_d;
    end
  end

  assign ent_valid_o = ent_valid_q;
  assign ent_o       = ent_q;

endmodule

FILE: hw/rtl/mscg_fifo.sv
// Short job queue between the front end and the blend pipeline.
`timescale 1ns / 1ps

module mscg_fifo #(
  parameter int unsigned DEPTH = mscg_pkg::FIFO_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  mscg_pkg::mscg_entry_t push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output mscg_pkg::mscg_entry_t pop_data_o
);
  import mscg_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  mscg_entry_t     mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/mscg_back.sv
// Blend pipeline: weighted sum per channel, then one quotient bit per stage.
`timescale 1ns / 1ps

module mscg_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  mscg_pkg::mscg_entry_t         job_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mscg_pkg::CHAN_W-1:0]   red_o,
  output logic [mscg_pkg::CHAN_W-1:0]   green_o,
  output logic [mscg_pkg::CHAN_W-1:0]   blue_o
);
  import mscg_pkg::*;

  logic                   v_q    [QUO_W+1];
  logic [POS_W-1:0]       span_q [QUO_W];
  logic [NUM_W-1:0]       rem_q  [QUO_W][LANES];
  logic [QUO_W-1:0]       quo_q  [QUO_W][LANES];
  logic [NUM_W-1:0]       rem_d  [QUO_W][LANES];
  logic [QUO_W-1:0]       quo_d  [QUO_W][LANES];
  logic [NUM_W-1:0]       num_d  [LANES];
  logic [POS_W-1:0]       rest_c;
  logic                   adv;

  // The whole pipeline moves together whenever the output slot can take a word.
  assign adv         = !v_q[QUO_W] || out_ready_i;
  assign job_ready_o = adv;
  assign rest_c      = job_i.span - job_i.offset;

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      num_d[c] = NUM_W'(job_i.lo_color[(LANES-1-c)*CHAN_W +: CHAN_W]) * NUM_W'(rest_c)
               + NUM_W'(job_i.hi_color[(LANES-1-c)*CHAN_W +: CHAN_W]) * NUM_W'(job_i.offset);
    end
  end

  // Restoring division: step i decides quotient bit QUO_W-1-i.
  always_comb begin
    for (int i = 0; i < QUO_W; i++) begin
      for (int c = 0; c < LANES; c++) begin
        logic [NUM_W-1:0] dsh;
        logic [QUO_W-1:0] qin;
        logic             ge;
        dsh = NUM_W'(span_q[i]) << (QUO_W - 1 - i);
        qin = (i == 0) ? '0 : quo_q[(i == 0) ? 0 : i - 1][c];
        ge  = (rem_q[i][c] >= dsh);
        rem_d[i][c] = ge ? rem_q[i][c] - dsh : rem_q[i][c];
        quo_d[i][c] = qin | (QUO_W'(ge) << (QUO_W - 1 - i));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QUO_W; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= job_valid_i;
      for (int i = 1; i <= QUO_W; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      span_q[0] <= job_i.span;
      for (int c = 0; c < LANES; c++) begin
        rem_q[0][c] <= num_d[c];
      end
      for (int i = 1; i < QUO_W; i++) begin
        span_q[i] <= span_q[i-1];
        for (int c = 0; c < LANES; c++) begin
          rem_q[i][c] <= rem_d[i-1][c];
        end
      end
      for (int i = 0; i < QUO_W; i++) begin
        for (int c = 0; c < LANES; c++) begin
          quo_q[i][c] <= quo_d[i][c];
        end
      end
    end
  end

  assign out_valid_o = v_q[QUO_W];
  assign red_o       = quo_q[QUO_W-1][0];
  assign green_o     = quo_q[QUO_W-1][1];
  assign blue_o      = quo_q[QUO_W-1][2];

endmodule

FILE: hw/rtl/multi_stop_color_gradient.sv
// Top level of the multi-stop colour gradient lookup.
`timescale 1ns / 1ps
//
// Maps a position on the input channel to an RGB colour on the output channel.
// Both channels use valid and ready; a word moves when both are high.
// Software programs the stop count and up to seven colour stops through the
// APB-style port, in ascending position order, while no word is in flight.
// With no stops the colour is black; below or at the first stop it is the
// first stop's colour; beyond the last valid stop it is that stop's colour;
// in between each channel is interpolated exactly and rounded down.
// A word accepted at the input is registered in the front end, then in the queue;
// the blend pipeline then registers the weighted sum and decides the eight
// quotient bits one per stage, the first of which is decided from the
// registered weighted sum.
// Throughput is one word per cycle while the receiver does not stall; the eight-step divider is pipelined.
// When the receiver stalls, the blend pipeline holds, the four-entry queue
// fills and the front end then stops accepting; nothing is lost.
// Reset clears the stop count, the stops and the valid flags, so the block starts out giving black.

module multi_stop_color_gradient #(
  parameter int unsigned MAX_STOPS     = mscg_pkg::MAX_STOPS_DEF,
  parameter int unsigned POSITION_SPAN = mscg_pkg::POSITION_SPAN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mscg_pkg::APB_AW-1:0]   paddr,
  input  logic [mscg_pkg::APB_DW-1:0]   pwdata,
  output logic [mscg_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mscg_pkg::POS_W-1:0]    position_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mscg_pkg::CHAN_W-1:0]   red_o,
  output logic [mscg_pkg::CHAN_W-1:0]   green_o,
  output logic [mscg_pkg::CHAN_W-1:0]   blue_o
);
  import mscg_pkg::*;

  logic [CNT_W-1:0] stop_count;
  mscg_stop_t       stops [NUM_STOP_REGS];
  logic             fe_valid;
  logic             fe_ready;
  mscg_entry_t      fe_entry;
  logic             job_valid;
  logic             job_ready;
  mscg_entry_t      job;

  mscg_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .stop_count_o (stop_count),
    .stops_o      (stops)
  );

  // The front end finds the bracketing stops and reduces every case to a blend job.
  mscg_front #(
    .MAX_STOPS     (MAX_STOPS),
    .POSITION_SPAN (POSITION_SPAN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .position_i   (position_i),
    .stop_count_i (stop_count),
    .stops_i      (stops),
    .ent_valid_o  (fe_valid),
    .ent_ready_i  (fe_ready),
    .ent_o        (fe_entry)
  );

  // The queue lets the front end keep taking words while the back end is held.
  mscg_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_entry),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_ready),
    .pop_data_o   (job)
  );

  // The back end forms the weighted sums and divides them by the stop spacing.
  mscg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule

FILE: hw/rtl/mscg_checker.sv
// Port-level checks of the gradient block, bound to its top level.
`timescale 1ns / 1ps

module mscg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [mscg_pkg::CHAN_W-1:0]   red_o,
  input logic [mscg_pkg::CHAN_W-1:0]   green_o,
  input logic [mscg_pkg::CHAN_W-1:0]   blue_o
);
  import mscg_pkg::*;

  // Front register, queue entries and every stage of the blend pipeline.
  localparam int unsigned Capacity = 1 + FIFO_DEPTH + QUO_W + 1;
  localparam int unsigned PendW    = $clog2(Capacity + 1);

  logic [PendW-1:0] pending_q;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + PendW'(1);
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - PendW'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable({red_o, green_o, blue_o}))
    else $error("output word changed while stalled");

  a_no_invented_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("output word without an accepted input word");

  a_bounded_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PendW'(Capacity))
    else $error("more words in flight than the block can hold");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == '0 |-> in_ready_o)
    else $error("empty block refuses input");

endmodule

bind multi_stop_color_gradient mscg_checker u_mscg_checker (.*);

FILE: bench/tb_multi_stop_color_gradient.sv
// Self-checking testbench for the multi-stop colour gradient lookup.
`timescale 1ns / 1ps

module tb_multi_stop_color_gradient;
  import mscg_pkg::*;

  // The block is built with its default parameters, so the bench uses the same values.
  localparam int unsigned STOPS_MAX  = MAX_STOPS_DEF;
  localparam int unsigned SPAN       = POSITION_SPAN_DEF;
  localparam int unsigned LIMIT      = 200000;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam int unsigned HOLD_LEN   = 64;
  localparam int unsigned SEGMENTS   = 10;
  localparam int unsigned SEG_WORDS  = 55;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  // A directed row either programs one register or sends one word. A word row
  // either carries its colour typed in or leaves it to the predictor.
  typedef struct packed {
    row_kind_e         kind;
    mscg_reg_e         reg_sel;
    logic [APB_DW-1:0] value;
    logic [POS_W-1:0]  pos;
    logic              fixed;
    rgb_t              colour;
  } dir_row_t;

  typedef enum int {
    CFG_SORTED, CFG_EXTREME, CFG_UNSORTED, CFG_FLAT, CFG_BLACK, CFG_GARBAGE
  } cfg_style_e;

  localparam int unsigned DIR_ROWS = 27;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [POS_W-1:0]  position_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CHAN_W-1:0] red_o;
  logic [CHAN_W-1:0] green_o;
  logic [CHAN_W-1:0] blue_o;

  // Shadow copy of the register file, updated at every write the bench makes.
  logic [CNT_W-1:0] count_q = '0;
  mscg_stop_t       stop_q [NUM_STOP_REGS];

  rgb_t        pending_colours [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        want_hold = 1'b0;

  // Directed rows: reset state, a three-stop ramp, the ends of the range,
  // shorter stop counts, stops written out of order and a count write whose
  // upper bits are all set and must be dropped.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd0, 1'b1, 24'h000000},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd1023, 1'b1, 24'h000000},
    '{ROW_CFG, REG_STOP_0, {30'd0, 10'd100, 24'h102030}, 10'd0, 1'b0, 24'h0},
    '{ROW_CFG, REG_STOP_1, {30'd0, 10'd300, 24'hF0E0D0}, 10'd0, 1'b0, 24'h0},
    '{ROW_CFG, REG_STOP_2, {30'd0, 10'd1023, 24'h00FF7F}, 10'd0, 1'b0, 24'h0},
    '{ROW_CFG, REG_STOP_COUNT, 64'd3, 10'd0, 1'b0, 24'h0},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd0, 1'b1, 24'h102030},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd100, 1'b1, 24'h102030},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd101, 1'b0, 24'h0},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd200, 1'b0, 24'h0},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd300, 1'b0, 24'h0},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd650, 1'b0, 24'h0},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd1023, 1'b1, 24'h00FF7F},
    '{ROW_CFG, REG_STOP_COUNT, 64'd2, 10'd0, 1'b0, 24'h0},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd1023, 1'b1, 24'hF0E0D0},
    '{ROW_CFG, REG_STOP_COUNT, 64'd1, 10'd0, 1'b0, 24'h0},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd0, 1'b1, 24'h102030},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd1023, 1'b1, 24'h102030},
    '{ROW_CFG, REG_STOP_COUNT, 64'd7, 10'd0, 1'b0, 24'h0},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd1023, 1'b0, 24'h0},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd500, 1'b0, 24'h0},
    '{ROW_CFG, REG_STOP_1, {30'd0, 10'd50, 24'hFF00FF}, 10'd0, 1'b0, 24'h0},
    '{ROW_CFG, REG_STOP_COUNT, 64'd3, 10'd0, 1'b0, 24'h0},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd80, 1'b1, 24'h102030},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd200, 1'b0, 24'h0},
    '{ROW_CFG, REG_STOP_COUNT, 64'hFFFF_FFFF_FFFF_FFF8, 10'd0, 1'b0, 24'h0},
    '{ROW_WORD, REG_STOP_COUNT, 64'd0, 10'd512, 1'b1, 24'h000000}
  };

  multi_stop_color_gradient DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o)
  );

  initial begin
    forever begin
      #1 clk_i = ~clk_i;
    end
  end

  // Positions above the span saturate to its top; with a ten-bit field and a
  // span of 1024 this never bites, but it keeps the predictor honest.
  function automatic int unsigned clip_pos(input int unsigned p);
    return (p > SPAN - 1) ? SPAN - 1 : p;
  endfunction

  // Exact weighted mean of two channel values, rounded down.
  function automatic logic [CHAN_W-1:0] mix_chan(input int unsigned lo_c,
                                                 input int unsigned hi_c,
                                                 input int unsigned span,
                                                 input int unsigned off);
    int unsigned v;
    v = (lo_c * (span - off) + hi_c * off) / span;
    return v[CHAN_W-1:0];
  endfunction

  function automatic rgb_t stop_colour(input int unsigned s);
    return rgb_t'({stop_q[s].red, stop_q[s].green, stop_q[s].blue});
  endfunction

  // Colour the block should give for one position under the shadow settings.
  function automatic rgb_t blend_colour(input logic [POS_W-1:0] pos);
    int unsigned n;
    int unsigned k;
    int unsigned p;
    int unsigned lo_p;
    int unsigned span;
    int unsigned off;
    rgb_t        c;
    n = count_q;
    if (n > STOPS_MAX) begin
      n = STOPS_MAX;
    end
    if (n == 0) begin
      return '0;
    end
    p = clip_pos(pos);
    for (k = 0; k < n; k++) begin
      if (p <= clip_pos(stop_q[k].pos)) begin
        break;
      end
    end
    if (k == n) begin
      return stop_colour(n - 1);
    end
    if (k == 0) begin
      return stop_colour(0);
    end
    // The first stop not below the position is k, so stop k-1 lies strictly
    // below it even when the stops are out of order: the span is never zero.
    lo_p    = clip_pos(stop_q[k-1].pos);
    span    = clip_pos(stop_q[k].pos) - lo_p;
    off     = p - lo_p;
    c.red   = mix_chan(stop_q[k-1].red, stop_q[k].red, span, off);
    c.green = mix_chan(stop_q[k-1].green, stop_q[k].green, span, off);
    c.blue  = mix_chan(stop_q[k-1].blue, stop_q[k].blue, span, off);
    return c;
  endfunction

  // Register writes happen only once every colour in flight has come back.
  // The input valid is lowered first, in the step that accepted the last word.
  // The task idles after the access so that back-to-back writes stay apart.
  task automatic write_reg(input mscg_reg_e sel, input logic [APB_DW-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_colours.size() != 0) begin
      @(posedge clk_i);
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_STOP_COUNT) begin
      count_q = value[CNT_W-1:0];
    end else begin
      stop_q[sel - REG_STOP_0] = mscg_stop_t'(value[STOP_W-1:0]);
    end
    @(posedge clk_i);
  endtask

  // Offers one word and returns in the step of the edge that accepted it, with
  // valid still high: the caller either offers the next word or lowers valid
  // in that same step, so valid is assigned only once per step.
  task automatic send_word(input logic [POS_W-1:0] pos, input logic fixed,
                           input rgb_t fixed_colour);
    rgb_t expected;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    position_i <= pos;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    expected = fixed ? fixed_colour : blend_colour(pos);
    pending_colours = {pending_colours, expected};
  endtask

  // Programs a fresh set of stops. Some sets are sorted as software would
  // write them; the others are extremes, unsorted, flat, empty or carry
  // junk in the unused upper data bits.
  task automatic program_stops(input cfg_style_e style);
    int unsigned       spots [$];
    logic [APB_DW-1:0] value;
    logic [CNT_W-1:0]  count;
    rgb_t              colour;
    int unsigned       i;
    int unsigned       flat;
    flat = $urandom_range(0, SPAN - 1);
    spots.delete();
    for (i = 0; i < NUM_STOP_REGS; i++) begin
      spots = {spots, $urandom_range(0, SPAN - 1)};
    end
    if (style == CFG_SORTED || style == CFG_GARBAGE || style == CFG_EXTREME) begin
      spots.sort();
    end
    if (style == CFG_EXTREME) begin
      spots[0] = 0;
      spots[NUM_STOP_REGS-1] = SPAN - 1;
    end
    for (i = 0; i < NUM_STOP_REGS; i++) begin
      colour = rgb_t'(COLOR_W'($urandom()));
      if (style == CFG_EXTREME) begin
        colour = (i % 2 == 0) ? '0 : '1;
      end
      value = '0;
      if (style == CFG_GARBAGE || $urandom_range(0, 3) == 0) begin
        value = {$urandom(), $urandom()};
      end
      value[STOP_W-1:0] = {(style == CFG_FLAT) ? flat[POS_W-1:0] : spots[i][POS_W-1:0],
                           colour};
      write_reg(mscg_reg_e'(REG_STOP_0 + i), value);
    end
    count = CNT_W'($urandom_range(1, STOPS_MAX));
    if (style == CFG_EXTREME) begin
      count = CNT_W'(STOPS_MAX);
    end else if (style == CFG_BLACK) begin
      count = '0;
    end
    value = (style == CFG_GARBAGE) ? {$urandom(), $urandom()} : '0;
    value[CNT_W-1:0] = count;
    write_reg(REG_STOP_COUNT, value);
  endtask

  // Positions cluster on and around the stops, where the search changes its
  // mind, with the rest spread over the whole range and its two ends.
  function automatic logic [POS_W-1:0] pick_position();
    int p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        p = $urandom_range(0, SPAN - 1);
      end
      4: begin
        p = ($urandom_range(0, 1) == 0) ? 0 : SPAN - 1;
      end
      default: begin
        p = int'(stop_q[$urandom_range(0, NUM_STOP_REGS - 1)].pos) +
            $urandom_range(0, 2) - 1;
        if (p < 0) begin
          p = 0;
        end else if (p > SPAN - 1) begin
          p = SPAN - 1;
        end
      end
    endcase
    return p[POS_W-1:0];
  endfunction

  // Receiver: stalls at random at the current rate, and on request holds off
  // for a long stretch so that the queue inside the block fills up and the
  // input side has to stall too.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Every colour taken from the block is checked against the oldest one owed.
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_colours.size() == 0) begin
        $display("%0t: colour %h %h %h with none expected", $time, red_o, green_o,
                 blue_o);
        errors++;
      end else begin
        want = pending_colours.pop_front();
        if (red_o !== want.red) begin
          $display("%0t: red expected %h, got %h", $time, want.red, red_o);
          errors++;
        end
        if (green_o !== want.green) begin
          $display("%0t: green expected %h, got %h", $time, want.green, green_o);
          errors++;
        end
        if (blue_o !== want.blue) begin
          $display("%0t: blue expected %h, got %h", $time, want.blue, blue_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_multi_stop_color_gradient failed");
      $finish;
    end
  end

  initial begin
    int unsigned seg;
    int unsigned n;
    cfg_style_e  style;
    for (n = 0; n < NUM_STOP_REGS; n++) begin
      stop_q[n] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, walked row by row with the output never stalled.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].reg_sel, dir_tab[i].value);
      end else begin
        send_word(dir_tab[i].pos, dir_tab[i].fixed, dir_tab[i].colour);
      end
    end

    // Random part: each segment reprograms the stops, then streams words.
    // The idle rates move from a slow receiver, to a slow sender, to full rate.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 6)
        1:       style = CFG_EXTREME;
        3:       style = CFG_UNSORTED;
        5:       style = (seg == 5) ? CFG_FLAT : CFG_GARBAGE;
        default: style = CFG_SORTED;
      endcase
      if (seg == 8) begin
        style = CFG_BLACK;
      end
      program_stops(style);
      if (seg < 3) begin
        send_idle_pct = 30;
        recv_idle_pct = 61;
      end else if (seg < 6) begin
        send_idle_pct = 61;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (n = 0; n < SEG_WORDS; n++) begin
        // Long receiver hold-offs while the sender keeps offering words.
        if ((seg == 1 || seg == 7) && n == 10) begin
          want_hold = 1'b1;
        end
        send_word(pick_position(), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_colours.size() != 0) begin
      @(posedge clk_i);
    end
    // The bench waits on so that any colour the block should not have sent shows up.
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_multi_stop_color_gradient passed");
    end else begin
      $display("tb_multi_stop_color_gradient failed");
    end
    $finish;
  end

endmodule
